>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
// each macro is defined twice: with checking for simulation, empty for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

>>> rtl/tcwt_pkg.sv
`default_nettype none

package tcwt_pkg;

    localparam int RATE_W  = 20;
    localparam int WORD_W  = 32;
    localparam int CLOCK_W = 6;

    localparam logic [RATE_W-1:0]  RATE_RESET = 20'd100;
    localparam logic [CLOCK_W-1:0] LAST_SEC   = 6'd59;
    localparam logic [CLOCK_W-1:0] LAST_MIN   = 6'd59;

    // floor(x / 1000) for any 32-bit x is (x * DIV_MAGIC) >> DIV_SHIFT
    localparam int DIV_MAGIC_W = 29;
    localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = 29'h10624DD3;
    localparam int DIV_SHIFT = 38;
    localparam int QUOT_W    = WORD_W + DIV_MAGIC_W;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ARM  = 2'd1,
        OP_POLL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_WAIT_OVF = 2'd0,
        PH_WAIT_DL  = 2'd1,
        PH_TIMED_OUT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_RECIP  = 2'd1,
        S_COMMIT = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic recip;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic arm_req;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/tcwt_ctrl.sv
`default_nettype none

module tcwt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    input  tcwt_pkg::dp_status_t    status,
    output tcwt_pkg::ctrl_cmd_t     cmd
);
    import tcwt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        out_free;
    logic        start;

    // the result slot is free when empty or being emptied this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) && out_free);
    assign start     = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.start = 1'b1;
                    if (status.arm_req)
                    begin
                        state_next = S_RECIP;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit     = 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tcwt_dp.sv
`default_nettype none

module tcwt_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tcwt_pkg::RATE_W-1:0]    cfg_wr_data,
    input  wire logic [1:0]                     operation,
    input  wire logic [tcwt_pkg::WORD_W-1:0]    delay_ms,
    input  tcwt_pkg::ctrl_cmd_t                 cmd,
    output tcwt_pkg::dp_status_t                status,
    output logic [tcwt_pkg::WORD_W-1:0]         tick_count,
    output logic [tcwt_pkg::CLOCK_W-1:0]        seconds,
    output logic [tcwt_pkg::CLOCK_W-1:0]        minutes,
    output logic [tcwt_pkg::WORD_W-1:0]         hours,
    output logic                                timed_out
);
    import tcwt_pkg::*;

    localparam int SPAN_W = QUOT_W - DIV_SHIFT;

    logic [RATE_W-1:0]  rate_reg;
    logic [WORD_W-1:0]  tick_reg,  tick_next;
    logic [RATE_W-1:0]  sub_reg,   sub_next;
    logic [CLOCK_W-1:0] sec_reg,   sec_next;
    logic [CLOCK_W-1:0] min_reg,   min_next;
    logic [WORD_W-1:0]  hour_reg,  hour_next;
    logic [WORD_W-1:0]  dl_reg,    dl_next;
    phase_t             phase_reg, phase_next;
    logic               flag_reg,  flag_next;

    logic [WORD_W-1:0]  prod_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [WORD_W-1:0]  rate_prod;
    logic [QUOT_W-1:0]  quot_prod;
    logic [RATE_W-1:0]  sub_inc;
    logic [SPAN_W-1:0]  span;

    assign status.arm_req = (op_t'(operation) == OP_ARM);

    // product is kept mod 2^32, as the deadline formula asks
    assign rate_prod = {{(WORD_W-RATE_W){1'b0}}, rate_reg} * delay_ms;
    assign quot_prod = {{DIV_MAGIC_W{1'b0}}, prod_reg} * {{WORD_W{1'b0}}, DIV_MAGIC};
    assign span      = quot_reg[QUOT_W-1:DIV_SHIFT];
    assign sub_inc   = sub_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            tick_reg  <= '0;
            sub_reg   <= '0;
            sec_reg   <= '0;
            min_reg   <= '0;
            hour_reg  <= '0;
            dl_reg    <= '0;
            phase_reg <= PH_TIMED_OUT;
            flag_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rate_reg <= cfg_wr_data;
            end
            tick_reg  <= tick_next;
            sub_reg   <= sub_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            dl_reg    <= dl_next;
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
        end
    end

    // arm pipeline, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            prod_reg <= rate_prod;
        end
        if (cmd.recip)
        begin
            quot_reg <= quot_prod;
        end
    end

    always_comb
    begin
        tick_next  = tick_reg;
        sub_next   = sub_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        dl_next    = dl_reg;
        phase_next = phase_reg;
        flag_next  = flag_reg;
        if (cmd.start)
        begin
            flag_next = 1'b0;
            case (op_t'(operation))
                OP_TICK:
                begin
                    tick_next = tick_reg + 1'b1;
                    if (sub_inc >= rate_reg)
                    begin
                        sub_next = '0;
                        if (sec_reg >= LAST_SEC)
                        begin
                            sec_next = '0;
                            if (min_reg >= LAST_MIN)
                            begin
                                min_next  = '0;
                                hour_next = hour_reg + 1'b1;
                            end
                            else
                            begin
                                min_next = min_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            sec_next = sec_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sub_next = sub_inc;
                    end
                end
                OP_POLL:
                begin
                    case (phase_reg)
                        PH_WAIT_OVF:
                        begin
                            if (!(dl_reg < tick_reg))
                            begin
                                phase_next = PH_WAIT_DL;
                            end
                        end
                        PH_WAIT_DL:
                        begin
                            if (!(tick_reg < dl_reg))
                            begin
                                phase_next = PH_TIMED_OUT;
                                flag_next  = 1'b1;
                            end
                        end
                        PH_TIMED_OUT:
                        begin
                            flag_next = 1'b1;
                        end
                        default:
                        begin
                            flag_next = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    flag_next = 1'b0;
                end
            endcase
        end
        if (cmd.commit)
        begin
            dl_next    = tick_reg + {{(WORD_W-SPAN_W){1'b0}}, span};
            phase_next = PH_WAIT_OVF;
            flag_next  = 1'b0;
        end
    end

    assign tick_count = tick_reg;
    assign seconds    = sec_reg;
    assign minutes    = min_reg;
    assign hours      = hour_reg;
    assign timed_out  = flag_reg;

endmodule

`default_nettype wire

>>> rtl/tick_clock_with_timeout.sv
// channel   handshake            payload
// request   req_valid/req_stall  operation, delay_ms
// result    rsp_valid/rsp_stall  tick_count, seconds, minutes, hours, timed_out
// config    cfg_wr_en            cfg_wr_data (tick_rate)
//
// tick, poll and idle operations: result shows the cycle after the transfer
// arm goes through a rate x ms multiply, a reciprocal multiply for /1000, then a deadline add
// one item in flight at a time; arm, with its multiplier chain, is the longest operation
// a new request is taken in the cycle the held result is transferred
// reset: tick_rate 100, clock and tick count zero, timeout reported as expired
`default_nettype none

`include "assert_macros.svh"

module tick_clock_with_timeout (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [tcwt_pkg::RATE_W-1:0]    cfg_wr_data,
    // request channel
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic [1:0]                     operation,
    input  wire logic [tcwt_pkg::WORD_W-1:0]    delay_ms,
    // result channel
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output logic [tcwt_pkg::WORD_W-1:0]         tick_count,
    output logic [tcwt_pkg::CLOCK_W-1:0]        seconds,
    output logic [tcwt_pkg::CLOCK_W-1:0]        minutes,
    output logic [tcwt_pkg::WORD_W-1:0]         hours,
    output logic                                timed_out
);
    import tcwt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: request acceptance, arm steps and the result valid flag
    tcwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // counters, clock, timeout slot and the arm arithmetic
    // result fields come straight off the state, which holds while a result waits
    tcwt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .operation   (operation),
        .delay_ms    (delay_ms),
        .cmd         (cmd),
        .status      (status),
        .tick_count  (tick_count),
        .seconds     (seconds),
        .minutes     (minutes),
        .hours       (hours),
        .timed_out   (timed_out)
    );

    // a request is never taken while a result is held back
    `ASSERT_NEVER(a_no_take_when_blocked, req_valid && !req_stall && rsp_valid && rsp_stall, "request taken while result stalled")

    // a non-arm operation gives its result straight after the transfer
    `ASSERT_CLK(a_short_op_result, req_valid && !req_stall && (operation != OP_ARM) |=> rsp_valid, "missing result after short operation")

    // the clock fields stay in range
    `ASSERT_CLK(a_clock_range, (seconds <= LAST_SEC) && (minutes <= LAST_MIN), "clock field out of range")

endmodule

`default_nettype wire

>>> tb/clock_timeout_checker.sv
`timescale 1ns / 1ps

module clock_timeout_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [tcwt_pkg::RATE_W-1:0] cfg_wr_data,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  logic [1:0]                  operation,
    input  logic [tcwt_pkg::WORD_W-1:0] delay_ms,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  logic [tcwt_pkg::WORD_W-1:0] tick_count,
    input  logic [tcwt_pkg::CLOCK_W-1:0] seconds,
    input  logic [tcwt_pkg::CLOCK_W-1:0] minutes,
    input  logic [tcwt_pkg::WORD_W-1:0] hours,
    input  logic                        timed_out,
    output int unsigned                 mismatch_count,
    output int unsigned                 results_owed,
    output int unsigned                 results_checked,
    output int unsigned                 expiries_seen
);
    import tcwt_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam logic [WORD_W-1:0] MS_PER_SECOND = 32'd1000;

    typedef struct packed {
        logic [WORD_W-1:0]  ticks;
        logic [CLOCK_W-1:0] secs;
        logic [CLOCK_W-1:0] mins;
        logic [WORD_W-1:0]  hrs;
        logic               expired;
    } clock_reading_t;

    clock_reading_t     owed_readings[$];

    // mirror of the block's state
    logic [RATE_W-1:0]  rate;
    logic [WORD_W-1:0]  ticks;
    logic [RATE_W-1:0]  subsec;
    logic [CLOCK_W-1:0] secs;
    logic [CLOCK_W-1:0] mins;
    logic [WORD_W-1:0]  hrs;
    logic [WORD_W-1:0]  due;
    phase_t             phase;

    int unsigned        errors;
    int unsigned        checked;
    int unsigned        expiries;

    function automatic clock_reading_t apply_request(input logic [1:0] op,
                                                     input logic [WORD_W-1:0] ms);
        logic [63:0]       product;
        logic [WORD_W-1:0] span;
        clock_reading_t    r;
        r.expired = 1'b0;
        case (op)
            OP_TICK:
            begin
                ticks  = ticks + 1'b1;
                subsec = subsec + 1'b1;
                if (subsec >= rate)
                begin
                    subsec = '0;
                    if (secs == LAST_SEC)
                    begin
                        secs = '0;
                        if (mins == LAST_MIN)
                        begin
                            mins = '0;
                            hrs  = hrs + 1'b1;
                        end
                        else
                            mins = mins + 1'b1;
                    end
                    else
                        secs = secs + 1'b1;
                end
            end
            OP_ARM:
            begin
                product = {44'd0, rate} * {32'd0, ms};
                span    = product[WORD_W-1:0] / MS_PER_SECOND;
                due     = ticks + span;
                phase   = PH_WAIT_OVF;
            end
            OP_POLL:
            begin
                case (phase)
                    PH_WAIT_OVF:
                        if (!(due < ticks))
                            phase = PH_WAIT_DL;
                    PH_WAIT_DL:
                        if (!(ticks < due))
                        begin
                            phase     = PH_TIMED_OUT;
                            r.expired = 1'b1;
                        end
                    PH_TIMED_OUT:
                        r.expired = 1'b1;
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.ticks = ticks;
        r.secs  = secs;
        r.mins  = mins;
        r.hrs   = hrs;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        clock_reading_t want;
        if (!rst_n)
        begin
            rate     = RATE_RESET;
            ticks    = '0;
            subsec   = '0;
            secs     = '0;
            mins     = '0;
            hrs      = '0;
            due      = '0;
            phase    = PH_TIMED_OUT;
            errors   = 0;
            checked  = 0;
            expiries = 0;
            owed_readings.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_readings.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result transfer with nothing owed: ticks %0d %0d:%0d:%0d exp %0b",
                                 $time, tick_count, hours, minutes, seconds, timed_out);
                end
                else
                begin
                    want = owed_readings.pop_front();
                    checked++;
                    if (timed_out === 1'b1)
                        expiries++;
                    if (tick_count !== want.ticks || seconds !== want.secs ||
                        minutes !== want.mins || hours !== want.hrs ||
                        timed_out !== want.expired)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display({"%0t: mismatch, expected ticks %0d %0d:%0d:%0d exp %0b,",
                                      " got ticks %0d %0d:%0d:%0d exp %0b"}, $time,
                                     want.ticks, want.hrs, want.mins, want.secs, want.expired,
                                     tick_count, hours, minutes, seconds, timed_out);
                    end
                end
            end
            if (cfg_wr_en)
                rate = cfg_wr_data;
            if (req_valid && !req_stall)
                owed_readings.push_back(apply_request(operation, delay_ms));
        end
        // published after the edge so the stimulus side reads settled values
        mismatch_count  <= errors;
        results_owed    <= owed_readings.size();
        results_checked <= checked;
        expiries_seen   <= expiries;
    end

endmodule

>>> tb/tick_clock_with_timeout_test.sv
`timescale 1ns / 1ps

module tick_clock_with_timeout_test;
    import tcwt_pkg::*;

    localparam int                LONG_HOLD      = 300;   // receiver hold-off, cycles
    localparam int                IDLE_LIMIT     = 2000;  // cycles with no transfer at all
    localparam int                SETTLE_CYCLES  = 8;     // extra wait after the last owed result
    localparam int                ROLLOVER_TICKS = 120;   // two full minutes at one tick per second
    localparam logic [1:0]        OP_UNUSED      = 2'd3;
    localparam logic [RATE_W-1:0] RATE_MIN       = 20'd19;
    localparam logic [RATE_W-1:0] RATE_MAX       = 20'd596591;
    localparam logic [RATE_W-1:0] RATE_ZERO      = 20'd0;
    localparam logic [RATE_W-1:0] RATE_ONE       = 20'd1;
    localparam logic [WORD_W-1:0] MS_ALL_ONES    = 32'hFFFF_FFFF;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [RATE_W-1:0]    cfg_wr_data = '0;
    logic                 req_valid   = 1'b0;
    logic                 req_stall;
    logic [1:0]           operation   = '0;
    logic [WORD_W-1:0]    delay_ms    = '0;
    logic                 rsp_valid;
    logic                 rsp_stall   = 1'b0;
    logic [WORD_W-1:0]    tick_count;
    logic [CLOCK_W-1:0]   seconds;
    logic [CLOCK_W-1:0]   minutes;
    logic [WORD_W-1:0]    hours;
    logic                 timed_out;

    int unsigned          mismatch_count;
    int unsigned          results_owed;
    int unsigned          results_checked;
    int unsigned          expiries_seen;

    // stimulus bookkeeping
    int unsigned          sent_total  = 0;
    int unsigned          sent_ticks  = 0;
    int unsigned          sent_arms   = 0;
    int unsigned          sent_polls  = 0;
    int unsigned          sent_unused = 0;
    bit                   no_idle     = 1'b0;   // both sides run flat out when set
    bit                   hold_pending = 1'b0;  // asks the receiver for one long hold-off
    int                   hold_left   = 0;
    int                   stall_left  = 0;
    int                   free_left   = 0;
    int                   quiet_cycles = 0;

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    tick_clock_with_timeout u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .delay_ms    (delay_ms),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .tick_count  (tick_count),
        .seconds     (seconds),
        .minutes     (minutes),
        .hours       (hours),
        .timed_out   (timed_out)
    );

    // prediction and comparison live beside the block
    clock_timeout_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .operation       (operation),
        .delay_ms        (delay_ms),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .tick_count      (tick_count),
        .seconds         (seconds),
        .minutes         (minutes),
        .hours           (hours),
        .timed_out       (timed_out),
        .mismatch_count  (mismatch_count),
        .results_owed    (results_owed),
        .results_checked (results_checked),
        .expiries_seen   (expiries_seen)
    );

    // mostly back to back, some short gaps, now and then a long one
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stall bursts, plus the one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (no_idle)
                rsp_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                rsp_stall <= 1'b0;
            end
            else
            begin
                stall_left = gap_cycles();
                free_left  = $urandom_range(0, 6);
                rsp_stall <= 1'b0;
            end
        end
    end

    // watchdog: the run is stuck if neither channel moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results owed",
                     IDLE_LIMIT, results_owed);
            $display("tick_clock_with_timeout_test NOT OK");
            $finish;
        end
    end

    // one request transfer; valid stays high afterwards so the next call can
    // follow back to back without touching it twice in one step
    task automatic send_item(input logic [1:0] op, input logic [WORD_W-1:0] ms);
        int gap;
        gap = no_idle ? 0 : gap_cycles();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        delay_ms  <= ms;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_total++;
        case (op)
            OP_TICK: sent_ticks++;
            OP_ARM:  sent_arms++;
            OP_POLL: sent_polls++;
            default: sent_unused++;
        endcase
    endtask

    // stop offering and wait until every owed result has been transferred
    task automatic settle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register writes only ever happen with the block idle
    task automatic write_rate(input logic [RATE_W-1:0] rate);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rate;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // arm, then interleave ticks and polls; short spans so most runs expire
    task automatic timeout_run(input logic [RATE_W-1:0] rate);
        logic [WORD_W-1:0] ms;
        int                steps;
        int                divisor;
        divisor = (rate < RATE_MIN) ? int'(RATE_MIN) : int'(rate);
        if ($urandom_range(0, 7) == 0)
            ms = $urandom();
        else
            ms = $urandom_range(0, 8000 / divisor);
        steps = $urandom_range(1, 24);
        send_item(OP_ARM, ms);
        repeat (steps)
            send_item($urandom_range(0, 1) ? OP_TICK : OP_POLL, $urandom());
        send_item(OP_POLL, $urandom());
    endtask

    // anything goes: all four codes, any delay
    task automatic noise_burst();
        logic [1:0] op;
        repeat ($urandom_range(1, 4))
        begin
            op = 2'($urandom_range(0, 3));
            send_item(op, $urandom());
        end
    endtask

    task automatic random_phase(input logic [RATE_W-1:0] rate, input int items,
                                input bit flat_out);
        int unsigned target;
        write_rate(rate);
        no_idle = flat_out;
        target  = sent_total + items;
        while (sent_total < target)
        begin
            if ($urandom_range(0, 9) < 7)
                timeout_run(rate);
            else
                noise_burst();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: state straight out of reset at the default rate
        send_item(OP_POLL, '0);              // nothing armed yet, reads as expired
        send_item(OP_UNUSED, MS_ALL_ONES);   // unused code changes nothing
        send_item(OP_TICK, '0);
        send_item(OP_ARM, '0);               // zero-length timeout
        send_item(OP_POLL, '0);
        send_item(OP_POLL, '0);
        send_item(OP_POLL, '0);              // expiry is sticky
        send_item(OP_ARM, MS_ALL_ONES);      // rate x ms wraps at 32 bits
        send_item(OP_POLL, '0);
        send_item(OP_POLL, '0);
        send_item(OP_ARM, 32'd30);           // three ticks at 100 per second
        send_item(OP_POLL, '0);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        send_item(OP_POLL, '0);
        send_item(OP_TICK, '0);
        send_item(OP_POLL, '0);
        send_item(OP_UNUSED, '0);
        send_item(OP_TICK, MS_ALL_ONES);     // delay ignored on a tick

        // rate one below the running subsecond count ends the second at once
        write_rate(RATE_ONE);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        // rate zero: every tick is a second
        write_rate(RATE_ZERO);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        write_rate(RATE_MAX);
        send_item(OP_ARM, MS_ALL_ONES);
        send_item(OP_POLL, '0);

        // two full minutes at one tick per second roll seconds and minutes
        write_rate(RATE_ONE);
        repeat (ROLLOVER_TICKS)
            send_item(OP_TICK, $urandom());

        // random phases over several rates; the first opens with a long
        // receiver hold-off, started with nothing owed, so the block backs up
        // and stalls its input while requests keep coming
        write_rate(RATE_MAX);
        hold_pending = 1'b1;
        random_phase(RATE_MAX, 115, 1'b0);
        // lowered well below the subsecond count built up above
        random_phase(RATE_MIN, 115, 1'b0);
        random_phase(RATE_W'($urandom_range(RATE_MIN, RATE_MAX)), 115, 1'b1);
        random_phase(RATE_W'($urandom_range(RATE_MIN, 200)), 115, 1'b0);
        random_phase(RATE_RESET, 115, 1'b0);
        random_phase(RATE_W'($urandom_range(RATE_MIN, RATE_MAX)), 100, 1'b0);

        settle();

        $display("covered %0d requests: %0d ticks, %0d arms, %0d polls, %0d unused codes",
                 sent_total, sent_ticks, sent_arms, sent_polls, sent_unused);
        $display("tick rates 0 to %0d, %0d results checked, %0d polls saw expiry",
                 RATE_MAX, results_checked, expiries_seen);
        if (mismatch_count == 0 && results_owed == 0)
            $display("tick_clock_with_timeout_test OK");
        else
            $display("tick_clock_with_timeout_test NOT OK");
        $finish;
    end

endmodule
